/* hdl/qsu_pkg.sv */
// ----------------------------------------------------------------------------
// qsu_pkg
// Types, codes and helper functions for the quoted string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

  localparam int unsigned MaxResults = 5;

  localparam logic [7:0]  ChQuote1  = 8'h27;
  localparam logic [7:0]  ChQuote2  = 8'h22;
  localparam logic [7:0]  ChBslash  = 8'h5C;
  localparam logic [7:0]  ChLbrace  = 8'h7B;
  localparam logic [7:0]  ChRbrace  = 8'h7D;
  localparam logic [7:0]  ChLf      = 8'h0A;
  localparam logic [7:0]  ChCr      = 8'h0D;
  localparam logic [7:0]  ChBel     = 8'h07;
  localparam logic [7:0]  ChBs      = 8'h08;
  localparam logic [7:0]  ChFf      = 8'h0C;
  localparam logic [7:0]  ChTab     = 8'h09;
  localparam logic [7:0]  ChVt      = 8'h0B;
  localparam logic [7:0]  ChSpace   = 8'h20;
  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] CpSat     = 21'h1FFFFF;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_BODY  = 4'd1,
    PH_ESC   = 4'd2,
    PH_CR    = 4'd3,
    PH_OCT   = 4'd4,
    PH_HEX1  = 4'd5,
    PH_HEX2  = 4'd6,
    PH_UOPEN = 4'd7,
    PH_UDIG  = 4'd8,
    PH_USKIP = 4'd9,
    PH_ZSKIP = 4'd10,
    PH_DONE  = 4'd11
  } phase_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eos;
    logic       err;
  } res_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h37);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChFf || c == ChLf || c == ChCr || c == ChTab ||
            c == ChVt || c == ChSpace);
  endfunction

endpackage

`default_nettype wire

/* hdl/quoted_string_unescaper_top.sv */
// ----------------------------------------------------------------------------
// quoted_string_unescaper_top
// Streaming decoder for quoted strings with backslash escapes.
// ----------------------------------------------------------------------------
// Takes one source byte per word and emits decoded bytes, an end word after
// the closing quote or the byte marked tlast, and error flags for bad unicode
// escapes. A leading single or double quote sets the closing quote, else a
// zero byte closes the string; tlast on an input word ends any open string
// and restarts the decoder for the next one. Each byte is decoded
// combinationally into a bundle of zero to five words, which is held in a
// small result buffer and drained through the output register at one word
// per cycle while the output side does not stall. The input therefore takes
// a byte every cycle as long as each byte yields at most one word and the
// output does not stall; a byte that yields more words (a unicode escape,
// an escape cut short by a plain byte, or flushed digits ahead of an end
// word) holds back the next byte while the buffer drains or output stalls.
`default_nettype none

module quoted_string_unescaper_top
  import qsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tlast,   // last_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [1:0]      m_axis_tuser,   // byte_valid, escape_error
  output logic            m_axis_tlast    // end_of_string
);

  // decoder state
  phase_t      phase, phase_next;
  logic [7:0]  cq, cq_next;
  logic [20:0] acc, acc_next;
  logic [2:0]  dcnt, dcnt_next;
  logic [7:0]  held, held_next;
  logic        ovf, ovf_next;

  // result bundle for the current byte
  res_t        res_c [MaxResults];
  logic [2:0]  k;

  // buffer of words still to send, head at index 0
  res_t        bres [MaxResults];
  logic [2:0]  brem;

  res_t        od;
  logic        out_load;
  logic        accept;

  logic [7:0]  b;
  logic        body;
  logic [4:0]  hv;
  logic [4:0]  hv_held;
  logic [8:0]  oct_acc;
  logic [24:0] uwide;
  logic        uerr;

  assign b        = s_axis_tdata;
  assign hv       = hex_val(b);
  assign hv_held  = hex_val(held);
  assign out_load = (brem != 3'd0) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (brem == 3'd0) || ((brem == 3'd1) && out_load);
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_next = phase;
    cq_next    = cq;
    acc_next   = acc;
    dcnt_next  = dcnt;
    held_next  = held;
    ovf_next   = ovf;
    body       = 1'b0;
    uerr       = 1'b0;
    k          = 3'd0;
    oct_acc    = {acc[5:0], b[2:0]};
    uwide      = {acc, hv[3:0]};
    for (int i = 0; i < MaxResults; i++) begin
      res_c[i] = '0;
    end

    unique case (phase)
      PH_START: begin
        phase_next = PH_BODY;
        if (b == ChQuote1 || b == ChQuote2) begin
          cq_next = b;
        end else begin
          cq_next = 8'h00;
          body    = 1'b1;
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        if (b == ChLf || b == 8'h6E) begin
          res_c[k] = '{data: ChLf, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == ChCr) begin
          res_c[k] = '{data: ChLf, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
          phase_next = PH_CR;
        end else if (b == 8'h61) begin
          res_c[k] = '{data: ChBel, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h62) begin
          res_c[k] = '{data: ChBs, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h66) begin
          res_c[k] = '{data: ChFf, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h72) begin
          res_c[k] = '{data: ChCr, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h74) begin
          res_c[k] = '{data: ChTab, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h76) begin
          res_c[k] = '{data: ChVt, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (b == 8'h78) begin
          phase_next = PH_HEX1;
        end else if (b == 8'h75) begin
          phase_next = PH_UOPEN;
        end else if (b == 8'h7A) begin
          phase_next = PH_ZSKIP;
        end else if (is_oct(b)) begin
          acc_next   = {18'd0, b[2:0]};
          dcnt_next  = 3'd1;
          phase_next = PH_OCT;
        end else begin
          res_c[k] = '{data: b, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end
      end
      PH_CR: begin
        phase_next = PH_BODY;
        // a lone lf right after the cr is swallowed
        body = (b != ChLf);
      end
      PH_OCT: begin
        if (is_oct(b)) begin
          acc_next  = {12'd0, oct_acc};
          dcnt_next = dcnt + 3'd1;
          if (dcnt_next >= 3'd3) begin
            res_c[k] = '{data: oct_acc[7:0], valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            phase_next = PH_BODY;
          end
        end else begin
          res_c[k] = '{data: acc[7:0], valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
          phase_next = PH_BODY;
          body       = 1'b1;
        end
      end
      PH_HEX1: begin
        if (!hv[4]) begin
          held_next  = b;
          phase_next = PH_HEX2;
        end else begin
          phase_next = PH_BODY;
          body       = 1'b1;
        end
      end
      PH_HEX2: begin
        phase_next = PH_BODY;
        if (!hv[4]) begin
          res_c[k] = '{data: {hv_held[3:0], hv[3:0]}, valid: 1'b1, eos: 1'b0,
                       err: 1'b0};
          k = k + 3'd1;
        end else begin
          res_c[k] = '{data: held, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
          body = 1'b1;
        end
      end
      PH_UOPEN: begin
        if (b == ChLbrace) begin
          acc_next   = '0;
          ovf_next   = 1'b0;
          phase_next = PH_UDIG;
        end else begin
          phase_next = PH_BODY;
          body       = 1'b1;
        end
      end
      PH_UDIG, PH_USKIP: begin
        if (b == ChRbrace) begin
          phase_next = PH_BODY;
          if (ovf || acc > CpMax) begin
            res_c[k] = '{data: 8'h00, valid: 1'b0, eos: 1'b0, err: 1'b1};
            k = k + 3'd1;
          end else if (acc < 21'h80) begin
            res_c[k] = '{data: acc[7:0], valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
          end else if (acc < 21'h800) begin
            res_c[k] = '{data: {3'b110, acc[10:6]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[5:0]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
          end else if (acc < 21'h10000) begin
            res_c[k] = '{data: {4'b1110, acc[15:12]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[11:6]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[5:0]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
          end else begin
            res_c[k] = '{data: {5'b11110, acc[20:18]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[17:12]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[11:6]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
            res_c[k] = '{data: {2'b10, acc[5:0]}, valid: 1'b1, eos: 1'b0, err: 1'b0};
            k = k + 3'd1;
          end
        end else if (b == cq) begin
          // closing quote inside an unterminated unicode escape
          res_c[k] = '{data: 8'h00, valid: 1'b0, eos: 1'b1, err: 1'b1};
          k = k + 3'd1;
          phase_next = PH_DONE;
        end else if (phase == PH_UDIG && !hv[4]) begin
          if (!ovf) begin
            if (uwide > {4'd0, CpMax}) begin
              ovf_next = 1'b1;
              acc_next = CpSat;
            end else begin
              acc_next = uwide[20:0];
            end
          end
        end else begin
          phase_next = PH_USKIP;
        end
      end
      PH_ZSKIP: begin
        if (!is_ws(b)) begin
          phase_next = PH_BODY;
          body       = 1'b1;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    // byte handed on as plain body text
    if (body) begin
      if (b == cq_next) begin
        res_c[k] = '{data: 8'h00, valid: 1'b0, eos: 1'b1, err: 1'b0};
        k = k + 3'd1;
        phase_next = PH_DONE;
      end else if (b == ChBslash) begin
        phase_next = PH_ESC;
      end else begin
        res_c[k] = '{data: b, valid: 1'b1, eos: 1'b0, err: 1'b0};
        k = k + 3'd1;
      end
    end

    // input ends: flush pending escape, close string, restart
    if (s_axis_tlast) begin
      if (phase_next != PH_DONE) begin
        if (phase_next == PH_OCT) begin
          res_c[k] = '{data: acc_next[7:0], valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (phase_next == PH_HEX2) begin
          res_c[k] = '{data: held_next, valid: 1'b1, eos: 1'b0, err: 1'b0};
          k = k + 3'd1;
        end else if (phase_next == PH_UDIG || phase_next == PH_USKIP) begin
          uerr = 1'b1;
        end
        res_c[k] = '{data: 8'h00, valid: 1'b0, eos: 1'b1, err: uerr};
        k = k + 3'd1;
      end
      phase_next = PH_START;
      cq_next    = 8'h00;
      acc_next   = '0;
      dcnt_next  = 3'd0;
      held_next  = 8'h00;
      ovf_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      cq    <= 8'h00;
      acc   <= '0;
      dcnt  <= 3'd0;
      held  <= 8'h00;
      ovf   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      cq    <= cq_next;
      acc   <= acc_next;
      dcnt  <= dcnt_next;
      held  <= held_next;
      ovf   <= ovf_next;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      brem <= 3'd0;
    end else if (accept) begin
      brem <= k;
    end else if (out_load) begin
      brem <= brem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MaxResults; i++) begin
        bres[i] <= res_c[i];
      end
    end else if (out_load) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        bres[i] <= bres[i + 1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      od <= bres[0];
    end
  end

  assign m_axis_tdata = od.data;
  assign m_axis_tuser = {od.err, od.valid};
  assign m_axis_tlast = od.eos;

endmodule

`default_nettype wire

/* tb/quoted_string_unescaper_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper_top_tb
// Self-checking bench for the quoted string decoder.
// ----------------------------------------------------------------------------
// Feeds source strings byte by byte: a few hand-written strings first, then
// random strings built from plain text and every kind of escape, with
// quoted and unquoted openings, clean closes, early ends, cut-off escapes and
// some raw noise. A behavioral decoder in the bench predicts every output
// word, and the output side compares each word against the oldest one
// predicted. Both sides idle at random, and some runs go without gaps.
// ----------------------------------------------------------------------------

module quoted_string_unescaper_top_tb;
  import qsu_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int MaxGap     = 10;
  localparam int TailCycles = 20;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  // decoder state as the bench sees it
  phase_t      dec_phase = PH_START;
  logic [7:0]  close_char = 8'h00;
  logic [20:0] acc = '0;
  logic [2:0]  oct_digits = '0;
  logic [7:0]  held_digit = 8'h00;
  logic        cp_overflow = 1'b0;
  int          step_words;

  res_t        decoded_words[$];
  res_t        want_word;
  logic [7:0]  frame_bytes[$];
  int          bad_words = 0;
  int          live_items = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  quoted_string_unescaper_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- decoder

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    case (c)
      ChFf, ChLf, ChCr, ChTab, ChVt, ChSpace: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic valid,
                                    input logic eos, input logic err);
    res_t w;
    w.data  = data;
    w.valid = valid;
    w.eos   = eos;
    w.err   = err;
    if (step_words < MaxResults) begin
      decoded_words.push_back(w);
      step_words++;
    end
  endfunction

  function automatic void emit_char(input logic [7:0] b);
    push_word(b, 1'b1, 1'b0, 1'b0);
  endfunction

  function automatic void end_string(input logic err);
    push_word(8'h00, 1'b0, 1'b1, err);
    dec_phase = PH_DONE;
  endfunction

  function automatic void clear_decoder();
    dec_phase   = PH_START;
    close_char  = 8'h00;
    acc         = '0;
    oct_digits  = '0;
    held_digit  = 8'h00;
    cp_overflow = 1'b0;
  endfunction

  // utf-8 encode the collected code point
  function automatic void emit_code_point();
    if (cp_overflow || acc > CpMax) begin
      push_word(8'h00, 1'b0, 1'b0, 1'b1);
    end else if (acc < 21'h80) begin
      emit_char(acc[7:0]);
    end else if (acc < 21'h800) begin
      emit_char({3'b110, acc[10:6]});
      emit_char({2'b10, acc[5:0]});
    end else if (acc < 21'h10000) begin
      emit_char({4'b1110, acc[15:12]});
      emit_char({2'b10, acc[11:6]});
      emit_char({2'b10, acc[5:0]});
    end else begin
      emit_char({5'b11110, acc[20:18]});
      emit_char({2'b10, acc[17:12]});
      emit_char({2'b10, acc[11:6]});
      emit_char({2'b10, acc[5:0]});
    end
    dec_phase = PH_BODY;
  endfunction

  function automatic void decode_source_byte(input logic [7:0] b, input logic l);
    bit          again;
    int          d;
    logic [24:0] wide;
    logic        err;
    step_words = 0;
    again = 1'b1;
    // some phases hand the same byte back to the body
    while (again) begin
      again = 1'b0;
      case (dec_phase)
        PH_START: begin
          dec_phase = PH_BODY;
          if (b == ChQuote1 || b == ChQuote2) begin
            close_char = b;
          end else begin
            close_char = ChNul;
            again = 1'b1;
          end
        end
        PH_BODY: begin
          if (b == close_char) begin
            end_string(1'b0);
          end else if (b == ChBslash) begin
            dec_phase = PH_ESC;
          end else begin
            emit_char(b);
          end
        end
        PH_ESC: begin
          dec_phase = PH_BODY;
          case (b)
            ChLf: emit_char(ChLf);
            ChCr: begin
              emit_char(ChLf);
              dec_phase = PH_CR;
            end
            "a": emit_char(ChBel);
            "b": emit_char(ChBs);
            "f": emit_char(ChFf);
            "n": emit_char(ChLf);
            "r": emit_char(ChCr);
            "t": emit_char(ChTab);
            "v": emit_char(ChVt);
            "x": dec_phase = PH_HEX1;
            "u": dec_phase = PH_UOPEN;
            "z": dec_phase = PH_ZSKIP;
            default: begin
              if (b >= "0" && b <= "7") begin
                acc = 21'(b - "0");
                oct_digits = 3'd1;
                dec_phase = PH_OCT;
              end else begin
                emit_char(b);
              end
            end
          endcase
        end
        PH_CR: begin
          dec_phase = PH_BODY;
          if (b != ChLf) again = 1'b1;
        end
        PH_OCT: begin
          if (b >= "0" && b <= "7") begin
            acc = ((acc << 3) | 21'(b - "0")) & 21'h1FF;
            oct_digits++;
            if (oct_digits >= 3'd3) begin
              emit_char(acc[7:0]);
              dec_phase = PH_BODY;
            end
          end else begin
            emit_char(acc[7:0]);
            dec_phase = PH_BODY;
            again = 1'b1;
          end
        end
        PH_HEX1: begin
          if (hex_digit_value(b) < 16) begin
            held_digit = b;
            dec_phase = PH_HEX2;
          end else begin
            dec_phase = PH_BODY;
            again = 1'b1;
          end
        end
        PH_HEX2: begin
          dec_phase = PH_BODY;
          d = hex_digit_value(b);
          if (d < 16) begin
            emit_char(8'((hex_digit_value(held_digit) << 4) | d));
          end else begin
            emit_char(held_digit);
            again = 1'b1;
          end
        end
        PH_UOPEN: begin
          if (b == ChLbrace) begin
            acc = '0;
            cp_overflow = 1'b0;
            dec_phase = PH_UDIG;
          end else begin
            dec_phase = PH_BODY;
            again = 1'b1;
          end
        end
        PH_UDIG, PH_USKIP: begin
          if (b == ChRbrace) begin
            emit_code_point();
          end else if (b == close_char) begin
            end_string(1'b1);
          end else begin
            d = hex_digit_value(b);
            if (dec_phase == PH_UDIG && d < 16) begin
              if (!cp_overflow) begin
                wide = {acc, 4'h0} | 25'(d);
                if (wide > 25'(CpMax)) begin
                  cp_overflow = 1'b1;
                  acc = CpSat;
                end else begin
                  acc = wide[20:0];
                end
              end
            end else begin
              dec_phase = PH_USKIP;
            end
          end
        end
        PH_ZSKIP: begin
          if (!is_blank(b)) begin
            dec_phase = PH_BODY;
            again = 1'b1;
          end
        end
        default: dec_phase = PH_DONE;
      endcase
    end
    // tlast flushes what is pending and closes the string
    if (l) begin
      if (dec_phase != PH_DONE) begin
        err = 1'b0;
        if (dec_phase == PH_OCT) begin
          emit_char(acc[7:0]);
        end else if (dec_phase == PH_HEX2) begin
          emit_char(held_digit);
        end else if (dec_phase == PH_UDIG || dec_phase == PH_USKIP) begin
          err = 1'b1;
        end
        end_string(err);
      end
      clear_decoder();
    end
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_word(input logic [7:0] b, input logic l);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (dec_phase != PH_DONE) live_items++;
    decode_source_byte(b, l);
  endtask

  task automatic send_bytes();
    foreach (frame_bytes[idx]) begin
      send_word(frame_bytes[idx], idx == frame_bytes.size() - 1);
    end
  endtask

  // stop sending and let every predicted word come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (decoded_words.size() != 0);
  endtask

  // ---------------------------------------------------------------- string builder

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    // lower or upper case letter
    return 8'(($urandom_range(0, 1) ? ChLowA : ChUpA) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_digit_value(b) < 16);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return ChFf;
      1: return ChLf;
      2: return ChCr;
      3: return ChTab;
      4: return ChVt;
      default: return ChSpace;
    endcase
  endfunction

  function automatic void push_plain(input logic [7:0] close);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == close || b == ChBslash);
    frame_bytes.push_back(b);
  endfunction

  // u{...} part of a unicode escape, spread over every utf-8 length
  function automatic void push_code_point();
    logic [31:0] cp;
    int          n;
    int          i;
    case ($urandom_range(0, 5))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: cp = $urandom_range('h800, 'hFFFF);
      3: cp = $urandom_range('h10000, 'h10FFFF);
      4: cp = $urandom_range('h110000, 'h1FFFFF);
      default: cp = $urandom;
    endcase
    frame_bytes.push_back("u");
    frame_bytes.push_back(ChLbrace);
    repeat ($urandom_range(0, 2)) frame_bytes.push_back("0");
    n = 1;
    while (n < 8 && (cp >> (4 * n)) != 0) n++;
    // zero may also come as empty braces
    if (!(cp == 0 && $urandom_range(0, 1))) begin
      for (i = n - 1; i >= 0; i--) frame_bytes.push_back(hex_char(cp[4 * i +: 4]));
    end
    if ($urandom_range(0, 5) == 0) frame_bytes.push_back(non_hex_byte());
    if ($urandom_range(0, 7) != 0) frame_bytes.push_back(ChRbrace);
  endfunction

  function automatic void push_escape();
    frame_bytes.push_back(ChBslash);
    case ($urandom_range(0, 13))
      0: begin
        case ($urandom_range(0, 6))
          0: frame_bytes.push_back("a");
          1: frame_bytes.push_back("b");
          2: frame_bytes.push_back("f");
          3: frame_bytes.push_back("n");
          4: frame_bytes.push_back("r");
          5: frame_bytes.push_back("t");
          default: frame_bytes.push_back("v");
        endcase
      end
      1: frame_bytes.push_back(ChLf);
      2: frame_bytes.push_back(ChCr);
      3: begin
        frame_bytes.push_back(ChCr);
        frame_bytes.push_back(ChLf);
      end
      4: begin
        frame_bytes.push_back("x");
        frame_bytes.push_back(hex_char($urandom_range(0, 15)));
        frame_bytes.push_back(hex_char($urandom_range(0, 15)));
      end
      5: begin
        frame_bytes.push_back("x");
        frame_bytes.push_back(hex_char($urandom_range(0, 15)));
        frame_bytes.push_back(non_hex_byte());
      end
      6: begin
        frame_bytes.push_back("x");
        frame_bytes.push_back(non_hex_byte());
      end
      7: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'("0" + $urandom_range(0, 7)));
      8, 9: push_code_point();
      10: begin
        frame_bytes.push_back("u");
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      11: begin
        frame_bytes.push_back("z");
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(blank_byte());
      end
      12: frame_bytes.push_back(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 3))
          0: frame_bytes.push_back(ChQuote1);
          1: frame_bytes.push_back(ChQuote2);
          2: frame_bytes.push_back(ChBslash);
          default: frame_bytes.push_back(ChNul);
        endcase
      end
    endcase
  endfunction

  // escape cut off by the end of input
  function automatic void push_cut_escape();
    frame_bytes.push_back(ChBslash);
    case ($urandom_range(0, 5))
      0: ;
      1: frame_bytes.push_back("x");
      2: begin
        frame_bytes.push_back("x");
        frame_bytes.push_back(hex_char($urandom_range(0, 15)));
      end
      3: frame_bytes.push_back("u");
      4: begin
        frame_bytes.push_back("u");
        frame_bytes.push_back(ChLbrace);
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(hex_char($urandom_range(0, 15)));
      end
      default: repeat ($urandom_range(1, 2)) frame_bytes.push_back(8'("0" + $urandom_range(0, 7)));
    endcase
  endfunction

  task automatic send_frame();
    logic [7:0] close;
    frame_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: close = ChQuote1;
        1: close = ChQuote2;
        default: close = ChNul;
      endcase
      if (close != ChNul) frame_bytes.push_back(close);
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 4) < 3) begin
          repeat ($urandom_range(1, 3)) push_plain(close);
        end else begin
          push_escape();
        end
      end
      case ($urandom_range(0, 5))
        4: ;  // tlast lands inside the open string
        5: push_cut_escape();
        default: begin
          frame_bytes.push_back(close);
          repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    send_bytes();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    idle_on = 1'b1;
    // unquoted string closed at once by a zero byte
    frame_bytes = '{ChNul};
    send_bytes();
    // three octal digits, then a fourth digit as text
    frame_bytes = '{ChQuote1, 8'hFF, ChBslash, "1", "2", "3", "4", ChQuote1};
    send_bytes();
    // x without digits, then a code point past the unicode range
    frame_bytes = '{ChQuote2, ChBslash, "x", "G", ChBslash, "u", ChLbrace,
                    "1", "1", "0", "0", "0", "0", ChRbrace, ChQuote2};
    send_bytes();
    // unicode escape left open when input ends
    frame_bytes = '{ChQuote2, ChBslash, "u", ChLbrace, "4"};
    send_bytes();
  endtask

  task automatic test_random_strings(input int upto);
    idle_on = 1'b1;
    while (live_items < upto) send_frame();
  endtask

  task automatic test_back_to_back(input int upto);
    idle_on = 1'b0;
    while (live_items < upto) send_frame();
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pauses();
    idle_on = 1'b1;
    repeat (8) begin
      send_frame();
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------- receiver and checks

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_left = idle_on ? $urandom_range(0, MaxGap) : 0;
      m_axis_tready <= (stall_left == 0);
    end else if (!m_axis_tready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_words.size() == 0) begin
        $display("%0t: unexpected word data %02h user %b last %b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        bad_words++;
      end else begin
        want_word = decoded_words.pop_front();
        if (m_axis_tdata !== want_word.data || m_axis_tuser[0] !== want_word.valid ||
            m_axis_tuser[1] !== want_word.err || m_axis_tlast !== want_word.eos) begin
          $display("%0t: expected data %02h valid %b err %b eos %b, actual %02h %b %b %b",
                   $time, want_word.data, want_word.valid, want_word.err, want_word.eos,
                   m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
          bad_words++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout", $time);
      $display("quoted_string_unescaper_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_strings(240);
    test_back_to_back(325);
    test_drain_pauses();
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (bad_words == 0 && decoded_words.size() == 0) begin
      $display("quoted_string_unescaper_top: match");
    end else begin
      $display("quoted_string_unescaper_top: mismatch");
    end
    $finish;
  end

endmodule
